// ===== hdl/sirg_pkg.sv =====
// sirg_pkg: field widths, command and health codes, register indexes and the
// state-change record shared by the sir graph node update block.
// No dependencies.
`default_nettype none

package sirg_pkg;

  localparam int CMD_W    = 2;
  localparam int NODE_F_W = 6;
  localparam int SLOT_F_W = 4;
  localparam int DEG_F_W  = 5;
  localparam int HL_W     = 2;
  localparam int PROB_BITS = 16;
  localparam int CNT_F_W  = 7;
  localparam int RATE_W   = 16;

  localparam logic [PROB_BITS-1:0] PROB_MASK = {PROB_BITS{1'b1}};

  // about 0.1 as a fraction of 65536
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd6554;

  localparam logic [CMD_W-1:0] CMD_SLOT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd2;

  localparam logic [HL_W-1:0] HL_S   = 2'd0;
  localparam logic [HL_W-1:0] HL_I   = 2'd1;
  localparam logic [HL_W-1:0] HL_R   = 2'd2;
  localparam logic [HL_W-1:0] HL_BAD = 2'd3;

  localparam logic REG_INFECT_RATE  = 1'b0;
  localparam logic REG_RECOVER_RATE = 1'b1;

  // one node moving between health states
  typedef struct packed {
    logic            en;
    logic [HL_W-1:0] src;
    logic [HL_W-1:0] dst;
  } health_move_t;

endpackage

`default_nettype wire

// ===== hdl/sirg_in_if.sv =====
// sirg_in_if: input channel of the sir graph node update block.
// Depends on sirg_pkg for field widths.
`default_nettype none

interface sirg_in_if;
  logic                             valid;
  logic                             ready;
  logic [sirg_pkg::CMD_W-1:0]       cmd;
  logic [sirg_pkg::NODE_F_W-1:0]    node;
  logic [sirg_pkg::SLOT_F_W-1:0]    slot;
  logic [sirg_pkg::NODE_F_W-1:0]    neighbour;
  logic [sirg_pkg::DEG_F_W-1:0]     degree;
  logic [sirg_pkg::HL_W-1:0]        health;
  logic [sirg_pkg::PROB_BITS-1:0]   rand_value;

  modport source (output valid, cmd, node, slot, neighbour, degree, health, rand_value,
                  input ready);
  modport sink (input valid, cmd, node, slot, neighbour, degree, health, rand_value,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/sirg_out_if.sv =====
// sirg_out_if: result channel of the sir graph node update block.
// Depends on sirg_pkg for field widths.
`default_nettype none

interface sirg_out_if;
  logic                            valid;
  logic                            ready;
  logic [sirg_pkg::HL_W-1:0]       node_health;
  logic                            changed;
  logic [sirg_pkg::DEG_F_W-1:0]    infected_neighbours;
  logic [sirg_pkg::CNT_F_W-1:0]    susceptible_count;
  logic [sirg_pkg::CNT_F_W-1:0]    infected_count;
  logic [sirg_pkg::CNT_F_W-1:0]    recovered_count;

  modport source (output valid, node_health, changed, infected_neighbours,
                  susceptible_count, infected_count, recovered_count, input ready);
  modport sink (input valid, node_health, changed, infected_neighbours,
                susceptible_count, infected_count, recovered_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/sir_graph_node_update.sv =====
// sir_graph_node_update: stochastic sir epidemic, one node update per step item.
// Depends on sirg_pkg, sirg_in_if, sirg_out_if, sirg_ram and sirg_counts.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+---------------------------------------------
//   in_ch    | in  | valid/ready         | cmd node slot neighbour degree health rand_value
//   out_ch   | out | valid/ready         | node_health changed infected_neighbours counts
//   apb      | in  | psel/penable/pwrite | paddr pwdata prdata pready (two rate registers)
//
// load, set and non-susceptible step items pass through the read and result states
// into the output register
// a step of a susceptible node adds a scan state over its degree slots and a decide
// state: neighbour slots and their health are read one a cycle
// through the adjacency and health memory ports
// after reset a clearing pass over all NODES entries zeroes health and degree; no item is
// taken meanwhile, rate writes are still taken
// the result sits in an output register; the block waits in its result state only
// while that register is still full
`default_nettype none

module sir_graph_node_update #(
  parameter int NODES      = 64,
  parameter int MAX_DEGREE = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sirg_in_if.sink          in_ch,
  sirg_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import sirg_pkg::*;

  localparam int NODE_W = $clog2(NODES);
  localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int ADJ_DEPTH = NODES * (2 ** SLOT_W);
  localparam int PROD_W = DEG_W + PROB_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  state_t state;

  // configuration
  logic [RATE_W-1:0] infect_rate;
  logic [RATE_W-1:0] recover_rate;
  logic              cfg_we;

  // latched item
  logic [CMD_W-1:0]     cmd_r;
  logic [NODE_F_W-1:0]  node_r;
  logic [SLOT_F_W-1:0]  slot_r;
  logic [NODE_F_W-1:0]  nb_r;
  logic [DEG_F_W-1:0]   deg_in_r;
  logic [HL_W-1:0]      hl_r;
  logic [PROB_BITS-1:0] rnd_r;
  logic                 in_range_r;

  // step working state
  logic [NODE_W-1:0] clr_idx;
  logic [HL_W-1:0]   nh_r;
  logic              changed_r;
  logic [DEG_W-1:0]  inf_cnt;
  logic [DEG_W-1:0]  deg_r;
  logic [DEG_W-1:0]  k;
  logic              v1;
  logic              v2;
  logic              nbok_r;

  // memories
  logic                      h_we;
  logic [NODE_W-1:0]         h_waddr;
  logic [HL_W-1:0]           h_wdata;
  logic [NODE_W-1:0]         h_raddr;
  logic [HL_W-1:0]           h_rdata;
  logic                      d_we;
  logic [NODE_W-1:0]         d_waddr;
  logic [DEG_W-1:0]          d_wdata;
  logic [DEG_W-1:0]          d_rdata;
  logic                      a_we;
  logic [NODE_W+SLOT_W-1:0]  a_waddr;
  logic [NODE_W+SLOT_W-1:0]  a_raddr;
  logic [NODE_F_W-1:0]       a_rdata;

  logic [NODE_W-1:0]    node_idx;
  logic [DEG_W-1:0]     deg_sat;
  logic [PROB_BITS-1:0] rnd_in;
  logic [PROD_W-1:0]    prod;
  logic                 recover_hit;
  logic                 infect_hit;
  logic                 in_acc;
  health_move_t         move;

  logic [CNT_W-1:0] cnt_s;
  logic [CNT_W-1:0] cnt_i;
  logic [CNT_W-1:0] cnt_r;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      infect_rate  <= RATE_RESET;
      recover_rate <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_INFECT_RATE:  infect_rate  <= pwdata[RATE_W-1:0];
        REG_RECOVER_RATE: recover_rate <= pwdata[RATE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INFECT_RATE:  prdata = 32'(infect_rate);
      REG_RECOVER_RATE: prdata = 32'(recover_rate);
      default:          prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign node_idx    = NODE_W'(node_r);
  assign deg_sat     = (32'(deg_in_r) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(deg_in_r);
  assign rnd_in      = in_ch.rand_value & PROB_MASK;

  assign prod        = PROD_W'(inf_cnt) * PROD_W'(infect_rate & PROB_MASK);
  assign recover_hit = rnd_r < (recover_rate & PROB_MASK);
  assign infect_hit  = PROD_W'(rnd_r) < prod;

  // health memory: read the item's node on accept, neighbours while scanning
  assign h_raddr = (state == ST_SCAN) ? NODE_W'(a_rdata) : NODE_W'(in_ch.node);
  assign h_waddr = (state == ST_CLEAR) ? clr_idx : node_idx;

  always_comb begin
    h_we     = 1'b0;
    h_wdata  = HL_S;
    move     = '0;
    move.src = h_rdata;
    move.dst = HL_S;
    unique case (state)
      ST_CLEAR: begin
        h_we = 1'b1;
      end
      ST_READ: begin
        if (in_range_r && cmd_r == CMD_SET && hl_r != HL_BAD) begin
          h_we     = 1'b1;
          h_wdata  = hl_r;
          move.en  = 1'b1;
          move.dst = hl_r;
        end else if (in_range_r && cmd_r == CMD_STEP && h_rdata == HL_I && recover_hit) begin
          h_we     = 1'b1;
          h_wdata  = HL_R;
          move.en  = 1'b1;
          move.dst = HL_R;
        end
      end
      ST_DECIDE: begin
        if (infect_hit) begin
          h_we     = 1'b1;
          h_wdata  = HL_I;
          move.en  = 1'b1;
          move.src = HL_S;
          move.dst = HL_I;
        end
      end
      default: ;
    endcase
  end

  assign d_we    = (state == ST_CLEAR) || (state == ST_READ && in_range_r && cmd_r == CMD_SET);
  assign d_waddr = (state == ST_CLEAR) ? clr_idx : node_idx;
  assign d_wdata = (state == ST_CLEAR) ? '0 : deg_sat;

  assign a_we    = (state == ST_READ) && in_range_r && (cmd_r == CMD_SLOT) &&
                   (32'(slot_r) < MAX_DEGREE);
  assign a_waddr = {node_idx, SLOT_W'(slot_r)};
  assign a_raddr = {node_idx, SLOT_W'(k)};

  sirg_ram #(.WIDTH(HL_W), .DEPTH(NODES)) u_health (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sirg_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_degree (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (NODE_W'(in_ch.node)),
    .rdata (d_rdata)
  );

  sirg_ram #(.WIDTH(NODE_F_W), .DEPTH(ADJ_DEPTH)) u_adjacency (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (nb_r),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  sirg_counts #(.NODES(NODES)) u_counts (
    .clk         (clk),
    .rst         (rst),
    .move        (move),
    .susceptible (cnt_s),
    .infected    (cnt_i),
    .recovered   (cnt_r)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // the result state reloads the output register itself
      if (out_ch.valid && out_ch.ready && state != ST_RESULT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == NODE_W'(NODES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r      <= in_ch.cmd;
            node_r     <= in_ch.node;
            slot_r     <= in_ch.slot;
            nb_r       <= in_ch.neighbour;
            deg_in_r   <= in_ch.degree;
            hl_r       <= in_ch.health;
            rnd_r      <= rnd_in;
            in_range_r <= 32'(in_ch.node) < NODES;
            changed_r  <= 1'b0;
            inf_cnt    <= '0;
            state      <= ST_READ;
          end
        end
        ST_READ: begin
          if (in_range_r && cmd_r == CMD_SET && hl_r != HL_BAD) begin
            nh_r  <= hl_r;
            state <= ST_RESULT;
          end else if (in_range_r && cmd_r == CMD_STEP && h_rdata == HL_I && recover_hit) begin
            nh_r      <= HL_R;
            changed_r <= 1'b1;
            state     <= ST_RESULT;
          end else if (in_range_r && cmd_r == CMD_STEP && h_rdata == HL_S) begin
            nh_r  <= h_rdata;
            deg_r <= d_rdata;
            k     <= '0;
            v1    <= 1'b0;
            v2    <= 1'b0;
            state <= ST_SCAN;
          end else begin
            nh_r  <= in_range_r ? h_rdata : HL_S;
            state <= ST_RESULT;
          end
        end
        ST_SCAN: begin
          // issue slot k, then its neighbour's health, then count
          if (k < deg_r) begin
            k  <= k + 1'b1;
            v1 <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2     <= v1;
          nbok_r <= 32'(a_rdata) < NODES;
          if (v2 && nbok_r && h_rdata == HL_I) begin
            inf_cnt <= inf_cnt + 1'b1;
          end
          if (k == deg_r && !v1 && !v2) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (infect_hit) begin
            nh_r      <= HL_I;
            changed_r <= 1'b1;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid               <= 1'b1;
            out_ch.node_health         <= nh_r;
            out_ch.changed             <= changed_r;
            out_ch.infected_neighbours <= DEG_F_W'(inf_cnt);
            out_ch.susceptible_count   <= CNT_F_W'(cnt_s);
            out_ch.infected_count      <= CNT_F_W'(cnt_i);
            out_ch.recovered_count     <= CNT_F_W'(cnt_r);
            state                      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    32'(cnt_s) + 32'(cnt_i) + 32'(cnt_r) == NODES)
    else $error("state counts do not add up to the node count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("item accepted while another is in work");

  a_changed_health: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.changed |-> out_ch.node_health != HL_S)
    else $error("changed node reported as susceptible");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> inf_cnt <= k)
    else $error("more infected neighbours than slots read");

endmodule

`default_nettype wire

// ===== hdl/sirg_ram.sv =====
// sirg_ram: generic one-write, one-read memory with registered read data.
// No dependencies.
`default_nettype none

module sirg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/sirg_counts.sv =====
// sirg_counts: running counts of susceptible, infected and recovered nodes.
// Depends on sirg_pkg for health codes and the move record.
`default_nettype none

module sirg_counts #(
  parameter int NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sirg_pkg::health_move_t       move,
  output logic      [$clog2(NODES+1)-1:0]   susceptible,
  output logic      [$clog2(NODES+1)-1:0]   infected,
  output logic      [$clog2(NODES+1)-1:0]   recovered
);

  import sirg_pkg::*;

  localparam int CNT_W = $clog2(NODES + 1);

  logic act;

  assign act = move.en && (move.src != move.dst);

  always_ff @(posedge clk) begin
    if (rst) begin
      susceptible <= CNT_W'(NODES);
      infected    <= '0;
      recovered   <= '0;
    end else if (act) begin
      if (move.src == HL_S) begin
        susceptible <= susceptible - 1'b1;
      end else if (move.dst == HL_S) begin
        susceptible <= susceptible + 1'b1;
      end
      if (move.src == HL_I) begin
        infected <= infected - 1'b1;
      end else if (move.dst == HL_I) begin
        infected <= infected + 1'b1;
      end
      if (move.src == HL_R) begin
        recovered <= recovered - 1'b1;
      end else if (move.dst == HL_R) begin
        recovered <= recovered + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for sir_graph_node_update, with a directed opening and
// random graph-building and update-step sequences under several rate settings.
// Depends on sirg_pkg, sirg_in_if, sirg_out_if and sir_graph_node_update from the rtl.
`default_nettype none

module testbench;
  import sirg_pkg::*;

  localparam int NODES      = 64;
  localparam int MAX_DEG    = 16;
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [NODE_F_W-1:0]  node;
    logic [SLOT_F_W-1:0]  slot;
    logic [NODE_F_W-1:0]  neighbour;
    logic [DEG_F_W-1:0]   degree;
    logic [HL_W-1:0]      health;
    logic [PROB_BITS-1:0] rand_value;
  } sir_item_t;

  typedef struct packed {
    logic [HL_W-1:0]    node_health;
    logic               changed;
    logic [DEG_F_W-1:0] infected_neighbours;
    logic [CNT_F_W-1:0] susceptible_count;
    logic [CNT_F_W-1:0] infected_count;
    logic [CNT_F_W-1:0] recovered_count;
  } node_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sirg_in_if  item_in ();
  sirg_out_if result_out ();

  sir_graph_node_update dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (item_in),
    .out_ch  (result_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // epidemic model: health, degree and neighbour lists, census and rates
  logic [HL_W-1:0]     model_health [NODES] = '{default: HL_S};
  int                  model_degree [NODES] = '{default: 0};
  logic [NODE_F_W-1:0] model_adjacency [NODES*MAX_DEG] = '{default: '0};
  int                  census [3] = '{NODES, 0, 0};
  logic [RATE_W-1:0]   model_infect = RATE_RESET;
  logic [RATE_W-1:0]   model_recover = RATE_RESET;

  // generator side: which neighbour slots hold a written value, planned degrees and rates
  bit                  slot_written [NODES*MAX_DEG] = '{default: 1'b0};
  int                  planned_degree [NODES] = '{default: 0};
  logic [RATE_W-1:0]   cur_infect = RATE_RESET;
  logic [RATE_W-1:0]   cur_recover = RATE_RESET;

  sir_item_t    items_to_send [$];
  node_result_t predicted_results [$];
  sir_item_t    next_item, taken_item;
  node_result_t want;

  int  items_queued, items_taken, results_seen, mismatches;
  int  infections_seen, recoveries_seen;
  int  send_gap, hold_left, idle_cycles;
  bit  calm;

  function automatic void move_health(input int n, input logic [HL_W-1:0] dst);
    if (model_health[n] == dst) return;
    census[model_health[n]]--;
    census[dst]++;
    model_health[n] = dst;
  endfunction

  function automatic node_result_t update_node_model(input sir_item_t it);
    node_result_t r;
    int n;
    int hits;
    r = '0;
    n = int'(it.node);
    hits = 0;
    case (it.cmd)
      CMD_SLOT: model_adjacency[n*MAX_DEG + it.slot] = it.neighbour;
      CMD_SET: begin
        model_degree[n] = (it.degree > MAX_DEG) ? MAX_DEG : it.degree;
        if (it.health != HL_BAD) move_health(n, it.health);
      end
      CMD_STEP: begin
        if (model_health[n] == HL_I) begin
          if (it.rand_value < model_recover) begin
            move_health(n, HL_R);
            r.changed = 1'b1;
          end
        end else if (model_health[n] == HL_S) begin
          for (int k = 0; k < model_degree[n]; k++)
            if (model_health[model_adjacency[n*MAX_DEG + k]] == HL_I) hits++;
          // exact product, no wrap at the rate width
          if (longint'(it.rand_value) < longint'(hits) * longint'(model_infect)) begin
            move_health(n, HL_I);
            r.changed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.node_health         = model_health[n];
    r.infected_neighbours = hits[DEG_F_W-1:0];
    r.susceptible_count   = census[HL_S][CNT_F_W-1:0];
    r.infected_count      = census[HL_I][CNT_F_W-1:0];
    r.recovered_count     = census[HL_R][CNT_F_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sir_item_t make_item(input logic [CMD_W-1:0] cmd,
                                          input logic [NODE_F_W-1:0] node);
    sir_item_t it;
    it.cmd        = cmd;
    it.node       = node;
    it.slot       = SLOT_F_W'($urandom_range(0, 15));
    it.neighbour  = NODE_F_W'($urandom_range(0, 63));
    it.degree     = DEG_F_W'($urandom_range(0, 31));
    it.health     = HL_W'($urandom_range(0, 3));
    it.rand_value = PROB_BITS'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic queue_item(input sir_item_t it);
    if (it.cmd == CMD_SLOT) slot_written[it.node*MAX_DEG + it.slot] = 1'b1;
    if (it.cmd == CMD_SET) planned_degree[it.node] = (it.degree > MAX_DEG) ? MAX_DEG : it.degree;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  task automatic queue_slot(input int node, input int slot, input int nb);
    sir_item_t it;
    it = make_item(CMD_SLOT, NODE_F_W'(node));
    it.slot = SLOT_F_W'(slot);
    it.neighbour = NODE_F_W'(nb);
    queue_item(it);
  endtask

  task automatic queue_set(input int node, input logic [HL_W-1:0] h, input int deg);
    sir_item_t it;
    it = make_item(CMD_SET, NODE_F_W'(node));
    it.health = h;
    it.degree = DEG_F_W'(deg);
    queue_item(it);
  endtask

  // a step may scan every slot within the degree, so fill unwritten ones first
  task automatic queue_step(input int node, input int rnd);
    sir_item_t it;
    for (int k = 0; k < planned_degree[node]; k++)
      if (!slot_written[node*MAX_DEG + k]) queue_slot(node, k, $urandom_range(0, 63));
    it = make_item(CMD_STEP, NODE_F_W'(node));
    it.rand_value = PROB_BITS'(rnd);
    queue_item(it);
  endtask

  function automatic int step_rand();
    int top;
    if ($urandom_range(0, 1)) return $urandom_range(0, 65535);
    top = 2 * ((2 * cur_infect > cur_recover) ? 2 * cur_infect : cur_recover) + 1;
    return $urandom_range(0, (top > 65535) ? 65535 : top);
  endfunction

  task automatic random_phase(input int count);
    int pick;
    int r;
    logic [HL_W-1:0] h;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        queue_slot($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 63));
      end else if (pick < 32) begin
        r = $urandom_range(0, 19);
        h = (r == 0) ? HL_BAD : (r < 9) ? HL_I : (r < 16) ? HL_S : HL_R;
        queue_set($urandom_range(0, 63), h,
                  ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16));
      end else if (pick < 96) begin
        queue_step($urandom_range(0, 63), step_rand());
      end else begin
        queue_item(make_item(CMD_NONE, NODE_F_W'($urandom_range(0, 63))));
      end
    end
  endtask

  task automatic write_rate(input logic idx, input logic [RATE_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_INFECT_RATE) cur_infect = value;
    else cur_recover = value;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
    if (got !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got);
      mismatches++;
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_in.valid <= 1'b0;
    end else if (!item_in.valid || item_in.ready) begin
      if (send_gap > 0) begin
        item_in.valid <= 1'b0;
        send_gap--;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        item_in.cmd        <= next_item.cmd;
        item_in.node       <= next_item.node;
        item_in.slot       <= next_item.slot;
        item_in.neighbour  <= next_item.neighbour;
        item_in.degree     <= next_item.degree;
        item_in.health     <= next_item.health;
        item_in.rand_value <= next_item.rand_value;
        item_in.valid      <= 1'b1;
        send_gap = pick_gap();
      end else begin
        item_in.valid <= 1'b0;
      end
    end
  end

  // result sink with random stalls
  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_out.ready <= 1'b0;
      hold_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      result_out.ready <= 1'b0;
      hold_left = pick_gap();
    end else begin
      result_out.ready <= 1'b1;
    end
  end

  // accepted items feed the model
  always @(posedge clk) begin
    if (!rst && item_in.valid && item_in.ready) begin
      taken_item.cmd        = item_in.cmd;
      taken_item.node       = item_in.node;
      taken_item.slot       = item_in.slot;
      taken_item.neighbour  = item_in.neighbour;
      taken_item.degree     = item_in.degree;
      taken_item.health     = item_in.health;
      taken_item.rand_value = item_in.rand_value;
      predicted_results.push_back(update_node_model(taken_item));
      items_taken++;
      // switch between stretches with random gaps and back-to-back stretches
      if (items_taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_INFECT_RATE) model_infect = pwdata[RATE_W-1:0];
      else if (paddr[2] == REG_RECOVER_RATE) model_recover = pwdata[RATE_W-1:0];
    end
  end

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      results_seen++;
      if (predicted_results.size() == 0) begin
        $display("%0t: result with no item pending, expected none got health %0d",
                 $time, result_out.node_health);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("node_health", 8'(want.node_health), 8'(result_out.node_health));
        check_field("changed", 8'(want.changed), 8'(result_out.changed));
        check_field("infected_neighbours", 8'(want.infected_neighbours),
                    8'(result_out.infected_neighbours));
        check_field("susceptible_count", 8'(want.susceptible_count),
                    8'(result_out.susceptible_count));
        check_field("infected_count", 8'(want.infected_count), 8'(result_out.infected_count));
        check_field("recovered_count", 8'(want.recovered_count),
                    8'(result_out.recovered_count));
        if (want.changed && want.node_health == HL_I) infections_seen++;
        if (want.changed && want.node_health == HL_R) recoveries_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_in.valid && item_in.ready) || (result_out.valid && result_out.ready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_in.valid      = 1'b0;
    item_in.cmd        = CMD_NONE;
    item_in.node       = '0;
    item_in.slot       = '0;
    item_in.neighbour  = '0;
    item_in.degree     = '0;
    item_in.health     = HL_S;
    item_in.rand_value = '0;
    result_out.ready   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_rate(REG_INFECT_RATE, 16'd16384);
    write_rate(REG_RECOVER_RATE, 16'd8192);

    queue_item(make_item(CMD_NONE, 6'd5));
    queue_step(63, 0);                       // susceptible node with no neighbours
    queue_slot(10, 0, 1);
    queue_slot(10, 1, 2);
    queue_slot(10, 2, 0);
    queue_slot(10, 15, 63);
    queue_set(1, HL_I, 0);
    queue_set(2, HL_I, 0);
    queue_set(63, HL_I, 0);
    queue_set(10, HL_S, 3);
    queue_step(10, 0);                       // two infected neighbours, infection
    queue_set(10, HL_S, 3);
    queue_step(10, 65535);                   // rand above threshold, stays susceptible
    queue_step(1, 0);                        // infected node recovers
    queue_step(2, 65535);                    // infected node stays infected
    queue_step(1, 0);                        // recovered node left alone
    queue_set(4, HL_BAD, 31);                // bad health code, degree saturates
    queue_set(4, HL_S, 16);
    queue_step(4, 0);
    wait_idle();

    for (int phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: begin
          write_rate(REG_INFECT_RATE, 16'd0);
          write_rate(REG_RECOVER_RATE, 16'hFFFF);
        end
        2: begin
          write_rate(REG_INFECT_RATE, 16'hFFFF);
          write_rate(REG_RECOVER_RATE, 16'd0);
        end
        3: begin
          write_rate(REG_INFECT_RATE, RATE_W'($urandom_range(0, 65535)));
          write_rate(REG_RECOVER_RATE, RATE_W'($urandom_range(0, 65535)));
        end
        default: begin
          write_rate(REG_INFECT_RATE, RATE_RESET);
          write_rate(REG_RECOVER_RATE, RATE_W'($urandom_range(1, 4000)));
        end
      endcase
      // slot fills ahead of steps add to these items
      random_phase(250);
      wait_idle();
    end

    $display("%0d items sent over five rate settings, %0d results compared",
             items_taken, results_seen);
    $display("%0d infections and %0d recoveries observed, %0d mismatches",
             infections_seen, recoveries_seen, mismatches);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sir_graph_node_update.f =====
hdl/sirg_pkg.sv
hdl/sirg_in_if.sv
hdl/sirg_out_if.sv
hdl/sirg_ram.sv
hdl/sirg_counts.sv
hdl/sir_graph_node_update.sv
tb/sv/testbench.sv
